@@ hw/rtl/multi_pin_switch_debouncer_core_macros.svh @@
// Assertion macros for the multi-pin debouncer core.
// Clock and reset names follow the project convention: clock, reset.
`ifndef MULTI_PIN_SWITCH_DEBOUNCER_CORE_MACROS_SVH
`define MULTI_PIN_SWITCH_DEBOUNCER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MPSD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/mpsd_pkg.sv @@
// Shared types and constants for the multi-pin debouncer core.
// No dependencies; used by mpsd_pin_lane and the top level.
package mpsd_pkg;

   localparam int LEVEL_W     = 16;
   localparam int TIMER_W     = 16;
   localparam int STAMP_W     = 32;
   localparam int PIN_IDX_W   = 4;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [1:0] {
      EVT_CLOSED   = 2'd0,
      EVT_OPENED   = 2'd1,
      EVT_RELEASED = 2'd2
   } event_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE    = 3'd0,
      CSR_ENABLE      = 3'd1,
      CSR_WAIT_CLOSED = 3'd2,
      CSR_BUTTON      = 3'd3,
      CSR_REPEAT      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic enable;
      logic wait_closed;
      logic button;
      logic repeat_en;
   } lane_cfg_type;

   typedef struct packed {
      logic                 fire;
      event_kind_type       kind;
      logic [STAMP_W-1:0]   held;
   } lane_evt_type;

endpackage

@@ hw/rtl/mpsd_pin_lane.sv @@
// One pin of the debouncer: edge detect, delay timer, button press/release tracking.
// Depends on mpsd_pkg.
module mpsd_pin_lane
   import mpsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                level,
   input  lane_cfg_type        cfg,
   input  logic [TIMER_W-1:0]  load_ticks,
   input  logic [STAMP_W-1:0]  tick_count,
   output lane_evt_type        evt
);

   logic               prev_ff, prev_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic               awaiting_ff, awaiting_in;
   logic               armed_ff, armed_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;

   logic               wait_close;
   logic               edge_hit;
   logic               confirm;
   logic [TIMER_W-1:0] timer_dec;

   always_comb begin
      prev_in     = level;
      timer_in    = timer_ff;
      awaiting_in = awaiting_ff;
      armed_in    = armed_ff;
      stamp_in    = stamp_ff;
      evt.fire    = 1'b0;
      evt.kind    = EVT_CLOSED;
      evt.held    = '0;
      wait_close  = cfg.button ? !awaiting_ff : cfg.wait_closed;
      edge_hit    = wait_close ? (prev_ff && !level) : (!prev_ff && level);
      timer_dec   = timer_ff - TIMER_W'(1);
      confirm     = 1'b0;

      if (!cfg.enable) begin
         timer_in    = '0;
         awaiting_in = 1'b0;
         armed_in    = 1'b1;
      end else if (!cfg.button || armed_ff) begin
         if (!cfg.button) begin
            awaiting_in = 1'b0;
            armed_in    = 1'b1;
         end
         if (edge_hit) begin
            timer_in = load_ticks;
         end else if (timer_ff != '0) begin
            timer_in = timer_dec;
            if (timer_dec == '0) begin
               confirm = wait_close ? !level : level;
            end
         end
         if (confirm) begin
            if (cfg.button) begin
               if (wait_close) begin
                  stamp_in    = tick_count;
                  awaiting_in = 1'b1;
               end else begin
                  evt.fire    = 1'b1;
                  evt.kind    = EVT_RELEASED;
                  evt.held    = tick_count - stamp_ff;
                  awaiting_in = 1'b0;
                  armed_in    = cfg.repeat_en;
               end
            end else begin
               evt.fire = 1'b1;
               evt.kind = wait_close ? EVT_CLOSED : EVT_OPENED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= 1'b1;
         timer_ff    <= '0;
         awaiting_ff <= 1'b0;
         armed_ff    <= 1'b1;
      end else if (step) begin
         prev_ff     <= prev_in;
         timer_ff    <= timer_in;
         awaiting_ff <= awaiting_in;
         armed_ff    <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         stamp_ff <= stamp_in;
      end
   end

endmodule

@@ hw/rtl/multi_pin_switch_debouncer_core.sv @@
// Multi-pin switch and button debouncer, one tick per request transfer.
// Path: request registers, then pending event flags, then the response registers.
// Throughput: one tick per cycle while ticks confirm no event; a tick with n events
// sends n responses, and the next tick is processed as its last one leaves.
// Reset (synchronous): pins open, timers idle, buttons armed, registers at defaults.
// Depends on mpsd_pkg, mpsd_pin_lane and multi_pin_switch_debouncer_core_macros.svh.
`include "multi_pin_switch_debouncer_core_macros.svh"

module multi_pin_switch_debouncer_core
   import mpsd_pkg::*;
#(
   parameter int PINS = 16
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [LEVEL_W-1:0]     csr_wdata,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [LEVEL_W-1:0]     req_pin_levels,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PIN_IDX_W-1:0]   rsp_pin_index,
   output logic [1:0]             rsp_event_kind,
   output logic [STAMP_W-1:0]     rsp_held_ticks,
   output logic                   rsp_last
);

   localparam int SEL_W = (PINS > 1) ? $clog2(PINS) : 1;

   logic [TIMER_W-1:0] debounce_ff;
   logic [LEVEL_W-1:0] enable_ff, wait_closed_ff, button_ff, repeat_ff;

   logic               in_valid_ff;
   logic [LEVEL_W-1:0] in_levels_ff;
   logic [STAMP_W-1:0] tick_count_ff;

   logic [PINS-1:0]    pend_ff, pend_in, pend_after, pop_onehot, lane_fire;
   event_kind_type     evt_kind_ff [PINS];
   logic [STAMP_W-1:0] evt_held_ff [PINS];

   logic                 rsp_valid_ff;
   logic [PIN_IDX_W-1:0] rsp_pin_index_ff;
   event_kind_type       rsp_event_kind_ff;
   logic [STAMP_W-1:0]   rsp_held_ff;
   logic                 rsp_last_ff;

   logic [TIMER_W-1:0] load_ticks;
   logic [SEL_W-1:0]   sel;
   logic               pop, proc_fire;
   lane_evt_type       lane_evt [PINS];

   for (genvar g = 0; g < PINS; g++) begin : gen_lane
      lane_cfg_type lane_cfg;
      assign lane_cfg.enable      = enable_ff[g];
      assign lane_cfg.wait_closed = wait_closed_ff[g];
      assign lane_cfg.button      = button_ff[g];
      assign lane_cfg.repeat_en   = repeat_ff[g];
      assign lane_fire[g]         = lane_evt[g].fire;

      mpsd_pin_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .step       (proc_fire),
         .level      (in_levels_ff[g]),
         .cfg        (lane_cfg),
         .load_ticks (load_ticks),
         .tick_count (tick_count_ff),
         .evt        (lane_evt[g])
      );
   end

   always_comb begin
      load_ticks = (debounce_ff == '0) ? TIMER_W'(1) : debounce_ff;
      sel = '0;
      for (int i = PINS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel = SEL_W'(i);
         end
      end
      pop_onehot      = '0;
      pop_onehot[sel] = 1'b1;
      pop        = (pend_ff != '0) && (!rsp_valid_ff || rsp_ready);
      pend_after = pop ? (pend_ff & ~pop_onehot) : pend_ff;
      proc_fire  = in_valid_ff && (pend_after == '0);
      pend_in    = proc_fire ? lane_fire : pend_after;
      req_ready  = !in_valid_ff || proc_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= TIMER_W'(20);
         enable_ff      <= '0;
         wait_closed_ff <= '0;
         button_ff      <= '0;
         repeat_ff      <= '0;
         in_valid_ff    <= 1'b0;
         tick_count_ff  <= '0;
         pend_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEBOUNCE:    debounce_ff    <= csr_wdata;
               CSR_ENABLE:      enable_ff      <= csr_wdata;
               CSR_WAIT_CLOSED: wait_closed_ff <= csr_wdata;
               CSR_BUTTON:      button_ff      <= csr_wdata;
               CSR_REPEAT:      repeat_ff      <= csr_wdata;
               default: ;
            endcase
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (proc_fire) begin
            tick_count_ff <= tick_count_ff + STAMP_W'(1);
         end
         pend_ff <= pend_in;
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_levels_ff <= req_pin_levels;
      end
      if (proc_fire) begin
         for (int i = 0; i < PINS; i++) begin
            evt_kind_ff[i] <= lane_evt[i].kind;
            evt_held_ff[i] <= lane_evt[i].held;
         end
      end
      if (pop) begin
         rsp_pin_index_ff  <= PIN_IDX_W'(sel);
         rsp_event_kind_ff <= evt_kind_ff[sel];
         rsp_held_ff       <= evt_held_ff[sel];
         rsp_last_ff       <= ((pend_ff & ~pop_onehot) == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pin_index  = rsp_pin_index_ff;
   assign rsp_event_kind = rsp_event_kind_ff;
   assign rsp_held_ticks = rsp_held_ff;
   assign rsp_last       = rsp_last_ff;

   `MPSD_ASSERT_IMPL(a_more_after_not_last, rsp_valid_ff && !rsp_last_ff, pend_ff != '0, "non-last response with nothing pending")
   `MPSD_ASSERT_IMPL(a_no_tick_over_pending, (pend_ff != '0) && !pop, !proc_fire, "tick processed over pending events")
   `MPSD_ASSERT_IMPL(a_switch_held_zero, rsp_valid_ff && (rsp_event_kind_ff != EVT_RELEASED), rsp_held_ff == '0, "switch event with nonzero hold time")

endmodule

@@ bench/debounce_event_checker.sv @@
// Event checker for multi_pin_switch_debouncer_core: tracks register writes and tick
// transfers, predicts the debounced pin events and compares them with the responses.
// Depends on mpsd_pkg.
module debounce_event_checker
   import mpsd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [LEVEL_W-1:0]     csr_wdata,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [LEVEL_W-1:0]     req_pin_levels,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [PIN_IDX_W-1:0]   rsp_pin_index,
   input  logic [1:0]             rsp_event_kind,
   input  logic [STAMP_W-1:0]     rsp_held_ticks,
   input  logic                   rsp_last,
   output int                     outstanding,
   output int                     failures
);

   localparam int PIN_COUNT = 16;
   localparam logic [TIMER_W-1:0] DEBOUNCE_DEFAULT = 16'd20;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [PIN_IDX_W-1:0] pin;
      event_kind_type       kind;
      logic [STAMP_W-1:0]   held;
      logic                 last;
   } pin_event_type;

   logic [TIMER_W-1:0] debounce_cfg;
   logic [LEVEL_W-1:0] enable_cfg;
   logic [LEVEL_W-1:0] wait_closed_cfg;
   logic [LEVEL_W-1:0] button_cfg;
   logic [LEVEL_W-1:0] rearm_cfg;

   logic [LEVEL_W-1:0] prev_level;
   logic [TIMER_W-1:0] settle_timer [PIN_COUNT];
   logic [LEVEL_W-1:0] awaiting_release;
   logic [LEVEL_W-1:0] armed;
   logic [STAMP_W-1:0] tick_now;
   logic [STAMP_W-1:0] press_tick [PIN_COUNT];

   pin_event_type expected_events[$];

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("%s", msg);
   endtask

   task automatic advance_tick(input logic [LEVEL_W-1:0] levels);
      logic [TIMER_W-1:0] reload;
      logic lvl;
      logic prev;
      logic watch_close;
      logic edge_hit;
      logic confirmed;
      pin_event_type ev;
      pin_event_type tick_events[$];
      reload = (debounce_cfg == '0) ? TIMER_W'(1) : debounce_cfg;
      for (int p = 0; p < PIN_COUNT; p++) begin
         lvl = levels[p];
         prev = prev_level[p];
         prev_level[p] = lvl;
         confirmed = 1'b0;
         if (!enable_cfg[p]) begin
            settle_timer[p] = '0;
            awaiting_release[p] = 1'b0;
            armed[p] = 1'b1;
         end else if (!button_cfg[p] || armed[p]) begin
            if (button_cfg[p]) begin
               watch_close = !awaiting_release[p];
            end else begin
               awaiting_release[p] = 1'b0;
               armed[p] = 1'b1;
               watch_close = wait_closed_cfg[p];
            end
            edge_hit = watch_close ? (prev && !lvl) : (!prev && lvl);
            if (edge_hit) begin
               settle_timer[p] = reload;
            end else if (settle_timer[p] != '0) begin
               settle_timer[p] = settle_timer[p] - TIMER_W'(1);
               if (settle_timer[p] == '0)
                  confirmed = watch_close ? !lvl : lvl;
            end
            if (confirmed) begin
               ev.pin = PIN_IDX_W'(p);
               ev.last = 1'b0;
               if (!button_cfg[p]) begin
                  ev.kind = watch_close ? EVT_CLOSED : EVT_OPENED;
                  ev.held = '0;
                  tick_events.push_back(ev);
               end else if (watch_close) begin
                  press_tick[p] = tick_now;
                  awaiting_release[p] = 1'b1;
               end else begin
                  ev.kind = EVT_RELEASED;
                  ev.held = tick_now - press_tick[p];
                  tick_events.push_back(ev);
                  awaiting_release[p] = 1'b0;
                  armed[p] = rearm_cfg[p];
               end
            end
         end
      end
      foreach (tick_events[i]) begin
         ev = tick_events[i];
         ev.last = (i == tick_events.size() - 1);
         expected_events.push_back(ev);
      end
      tick_now = tick_now + STAMP_W'(1);
   endtask

   always @(posedge clock) begin
      pin_event_type want;
      string exp_s;
      string act_s;
      if (reset) begin
         debounce_cfg = DEBOUNCE_DEFAULT;
         enable_cfg = '0;
         wait_closed_cfg = '0;
         button_cfg = '0;
         rearm_cfg = '0;
         prev_level = '1;
         awaiting_release = '0;
         armed = '1;
         tick_now = '0;
         for (int p = 0; p < PIN_COUNT; p++) begin
            settle_timer[p] = '0;
            press_tick[p] = '0;
         end
         expected_events.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               log_failure($sformatf("unexpected event: pin %0d kind %0d held %0d last %0d",
                  rsp_pin_index, rsp_event_kind, rsp_held_ticks, rsp_last));
            end else begin
               want = expected_events.pop_front();
               if (rsp_pin_index !== want.pin || rsp_event_kind !== want.kind ||
                   rsp_held_ticks !== want.held || rsp_last !== want.last) begin
                  exp_s = $sformatf("pin %0d kind %0d held %0d last %0d",
                     want.pin, want.kind, want.held, want.last);
                  act_s = $sformatf("pin %0d kind %0d held %0d last %0d",
                     rsp_pin_index, rsp_event_kind, rsp_held_ticks, rsp_last);
                  log_failure({"event mismatch: expected ", exp_s, ", got ", act_s});
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DEBOUNCE:    debounce_cfg = csr_wdata;
               CSR_ENABLE:      enable_cfg = csr_wdata;
               CSR_WAIT_CLOSED: wait_closed_cfg = csr_wdata;
               CSR_BUTTON:      button_cfg = csr_wdata;
               CSR_REPEAT:      rearm_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            advance_tick(req_pin_levels);
      end
      outstanding <= expected_events.size();
   end

endmodule

@@ bench/multi_pin_switch_debouncer_core_test.sv @@
// Top of the multi_pin_switch_debouncer_core bench: clock, reset, register setup,
// tick stimulus with bursty transfers and a stalling receiver, and the verdict.
// Depends on mpsd_pkg, debounce_event_checker and the core RTL.
module multi_pin_switch_debouncer_core_test;
   import mpsd_pkg::*;

   localparam int DRAIN_CYCLES = 32;
   localparam int RANDOM_PHASES = 8;
   localparam int TICKS_PER_PHASE = 25;
   localparam int TIME_LIMIT = 4_000_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [LEVEL_W-1:0]     csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [LEVEL_W-1:0]     req_pin_levels = '1;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [PIN_IDX_W-1:0]   rsp_pin_index;
   logic [1:0]             rsp_event_kind;
   logic [STAMP_W-1:0]     rsp_held_ticks;
   logic                   rsp_last;

   int outstanding;
   int failures;
   int burst_left = 0;
   int stall_mode = 0;
   int mode_left = 0;

   multi_pin_switch_debouncer_core dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pin_levels (req_pin_levels),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pin_index  (rsp_pin_index),
      .rsp_event_kind (rsp_event_kind),
      .rsp_held_ticks (rsp_held_ticks),
      .rsp_last       (rsp_last)
   );

   debounce_event_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pin_levels (req_pin_levels),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pin_index  (rsp_pin_index),
      .rsp_event_kind (rsp_event_kind),
      .rsp_held_ticks (rsp_held_ticks),
      .rsp_last       (rsp_last),
      .outstanding    (outstanding),
      .failures       (failures)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: stretches of no stall, light, heavy and rare stalls
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left <= $urandom_range(16, 80);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   task automatic send_tick(input logic [LEVEL_W-1:0] levels);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_pin_levels <= levels;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [LEVEL_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [LEVEL_W-1:0] debounce, input logic [LEVEL_W-1:0] enable,
                             input logic [LEVEL_W-1:0] wait_closed,
                             input logic [LEVEL_W-1:0] button, input logic [LEVEL_W-1:0] rearm);
      write_csr(CSR_DEBOUNCE, debounce);
      write_csr(CSR_ENABLE, enable);
      write_csr(CSR_WAIT_CLOSED, wait_closed);
      write_csr(CSR_BUTTON, button);
      write_csr(CSR_REPEAT, rearm);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [LEVEL_W-1:0] pin_state;
      logic [LEVEL_W-1:0] flips;
      logic [LEVEL_W-1:0] debounce_pick;
      int pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // all pins disabled: levels tracked, no events
      send_tick('0);
      send_tick('1);
      quiesce();

      // all switches wait for closing; writes to unmapped indexes must not land
      write_csr(CSR_DEBOUNCE, 16'd1);
      write_csr(CSR_REPEAT, '0);
      write_csr(CSR_BUTTON, '0);
      write_csr(CSR_WAIT_CLOSED, '1);
      write_csr(CSR_ENABLE, '1);
      for (int i = int'(CSR_REPEAT) + 1; i < (1 << CSR_INDEX_W); i++)
         write_csr(CSR_INDEX_W'(i), '0);
      csr_we <= 1'b0;
      send_tick('0);
      send_tick('0);
      send_tick('1);
      send_tick('1);
      quiesce();

      // zero debounce, mixed switches and buttons, half of the buttons disarm
      set_config(16'd0, '1, 16'h00FF, 16'hF000, 16'h5000);
      send_tick('0);
      send_tick('0);
      send_tick('1);
      send_tick('1);
      send_tick('0);
      send_tick('0);
      send_tick('1);
      send_tick('1);
      quiesce();

      // bounce with reload, then a failed confirming sample
      set_config(16'd2, '1, '1, '0, '0);
      send_tick('0);
      send_tick('1);
      send_tick('0);
      send_tick('0);
      send_tick('0);
      send_tick('1);
      send_tick('0);
      send_tick('1);
      send_tick('1);
      quiesce();

      // longest debounce
      set_config('1, '1, '1, '0, '0);
      send_tick('0);
      send_tick('0);
      quiesce();

      pin_state = '0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick = $urandom_range(0, 9);
         if (pick < 7)
            debounce_pick = LEVEL_W'($urandom_range(0, 3));
         else if (pick < 9)
            debounce_pick = LEVEL_W'($urandom_range(4, 24));
         else
            debounce_pick = LEVEL_W'($urandom);
         set_config(debounce_pick, LEVEL_W'($urandom | $urandom), LEVEL_W'($urandom),
                    LEVEL_W'($urandom), LEVEL_W'($urandom));
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            if ($urandom_range(0, 9) == 0)
               flips = LEVEL_W'($urandom);
            else
               flips = LEVEL_W'($urandom & $urandom & $urandom);
            pin_state = pin_state ^ flips;
            send_tick(pin_state);
         end
         quiesce();
      end

      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #(TIME_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
